// ----- rtl/core/mtgrm_pkg.sv -----
package mtgrm_pkg;

   // item codes carried in the low bits of req_tuser
   localparam logic [1:0] FUNC_MIX  = 2'd0;
   localparam logic [1:0] FUNC_SET  = 2'd1;
   localparam logic [1:0] FUNC_RAMP = 2'd2;
   localparam logic [1:0] FUNC_END  = 2'd3;

   // register map: register index is paddr[2]
   localparam int          CSR_ADDR_W      = 3;
   localparam logic        REG_RAMP_FRAMES = 1'b0;
   localparam logic [15:0] RAMP_FRAMES_RST = 16'd1024;

   localparam int DVD_W = 31;   // |target delta| in 16.16, 15 integer bits
   localparam int DVS_W = 16;   // ramp_frames

   localparam logic [14:0] GAIN_UNITY = 15'd4096;

   typedef struct packed {
      logic [31:0] now;    // 16.16 running gain
      logic [31:0] step;   // 16.16 ramp step
      logic [14:0] tgt;    // 4.12 target gain
   } entry_type;

   localparam entry_type ENTRY_RESET = '{now: 32'h1000_0000, step: 32'd0, tgt: GAIN_UNITY};

   // 4.12 gain as 16.16
   function automatic logic [31:0] to_q16(input logic [14:0] g);
      return {1'b0, g, 16'd0};
   endfunction

   // shift right 12 and clamp to 16 bits
   function automatic logic [15:0] sat16(input logic [31:0] acc);
      logic [19:0] h;
      h = acc[31:12];
      if (!h[19] && (|h[18:15])) return 16'h7FFF;
      if (h[19] && !(&h[18:15])) return 16'h8000;
      return h[15:0];
   endfunction

endpackage

// ----- rtl/core/multitrack_gain_ramp_mixer.sv -----
// Stereo mixer for 16-bit PCM from up to TRACKS tracks, one word per track sample or
// gain command. The block takes one word at a time and accepts the next only once the
// last is through: each word reads both table entries of its track, a mix word then
// multiplies and accumulates left and right in turn, a ramped set-gain waits for the
// divider, and a mix word that closes a frame waits until its result is loaded. The
// work is done by the gain table, a memory with one read and one write port that is
// fetched for both channels of the track, by the single shared 16x16 multiplier and
// accumulate adder that serve left and right in turn, and by the bit-serial divider
// that computes a ramp step. Gain entries read as unity until written, tracked by one
// valid bit per entry, so no clearing pass runs after reset. A closed frame waits in
// the output register while the next words are accepted.
module multitrack_gain_ramp_mixer import mtgrm_pkg::*; #(
   parameter int TRACKS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // track[4:0], channel[5], gain_value[20:6], sample_left[36:21],
   // sample_right[52:37], zero[55:53]
   input  logic [55:0]           req_tdata,
   // func[1:0], mono[2]
   input  logic [2:0]            req_tuser,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // mix_left[15:0], mix_right[31:16]
   output logic [31:0]           rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int ENTRIES = 2 * TRACKS;
   localparam int IDX_W   = $clog2(ENTRIES);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RD1  = 4'd1;
   localparam logic [3:0] S_RD2  = 4'd2;
   localparam logic [3:0] S_DEC  = 4'd3;
   localparam logic [3:0] S_MUL  = 4'd4;
   localparam logic [3:0] S_ACC  = 4'd5;
   localparam logic [3:0] S_FIN  = 4'd6;
   localparam logic [3:0] S_DIV  = 4'd7;
   localparam logic [3:0] S_EMIT = 4'd8;

   // input word fields
   logic [4:0]  req_track;
   assign req_track = req_tdata[4:0];

   logic [3:0]  state_ff, state_in;
   logic        sel_ff, sel_in;
   logic [1:0]  func_ff;
   logic [4:0]  trk_ff;
   logic        trk_ok_ff;
   logic        ch_ff;
   logic [14:0] gv_ff;
   logic [15:0] sl_ff, sr_ff;
   logic        mono_ff, last_ff;
   entry_type   ent_ff [2];
   logic [31:0] acc_ff [2];
   logic [31:0] acc_in [2];
   logic signed [31:0] prod_ff;
   logic [15:0] ramp_frames_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;

   // gain table
   entry_type            mem [ENTRIES];
   entry_type            mem_rd_ff;
   logic                 vld_rd_ff;
   logic [ENTRIES-1:0]   vld_ff;
   logic [5:0]           rd_addr, wr_addr;
   logic [IDX_W-1:0]     rd_idx, wr_idx;
   logic                 wr_en, wr_ch;
   entry_type            wr_data;
   entry_type            rd_ent;

   logic req_acc, rsp_load, csr_wr;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_tready);

   assign rd_addr = (state_ff == S_IDLE) ? {req_track, 1'b0} : {trk_ff, 1'b1};
   assign wr_addr = {trk_ff, wr_ch};
   assign rd_idx  = rd_addr[IDX_W-1:0];
   assign wr_idx  = wr_addr[IDX_W-1:0];
   assign rd_ent  = vld_rd_ff ? mem_rd_ff : ENTRY_RESET;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_idx] <= wr_data;
      mem_rd_ff <= mem[rd_idx];
      vld_rd_ff <= vld_ff[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_idx] <= 1'b1;
      end
   end

   // shared datapath operands
   entry_type          ent_cur, ent_sel;
   logic               ramping;
   logic [31:0]        adv_sum;
   logic signed [15:0] gain_op, samp_op;
   logic signed [15:0] ahead, tgt_s;
   logic signed [31:0] step_s;
   logic               fin_hit;
   logic [15:0]        dg, dg_mag;
   logic               dg_neg;
   logic [DVD_W-1:0]   dividend, quotient;
   logic [DVS_W-1:0]   divisor;
   logic [31:0]        step_new;
   logic               div_start, div_done;

   assign ent_cur = ent_ff[sel_ff];
   assign ent_sel = ent_ff[ch_ff];
   assign ramping = |(ent_ff[0].step | ent_ff[1].step);
   assign adv_sum = ent_cur.now + ent_cur.step;
   assign gain_op = ramping ? $signed(ent_cur.now[31:16]) : $signed({1'b0, ent_cur.tgt});
   assign samp_op = (sel_ff && !mono_ff) ? $signed(sr_ff) : $signed(sl_ff);

   assign ahead   = $signed(adv_sum[31:16]);
   assign tgt_s   = $signed({1'b0, ent_cur.tgt});
   assign step_s  = $signed(ent_cur.step);
   assign fin_hit = (step_s > 0 && ahead >= tgt_s) || (step_s < 0 && ahead <= tgt_s);

   assign dg       = {1'b0, gv_ff} - {1'b0, ent_sel.tgt};
   assign dg_neg   = dg[15];
   assign dg_mag   = dg_neg ? (16'd0 - dg) : dg;
   assign dividend = {dg_mag[14:0], 16'd0};
   assign divisor  = (ramp_frames_ff == 16'd0) ? 16'd1 : ramp_frames_ff;
   assign step_new = dg_neg ? (32'd0 - {1'b0, quotient}) : {1'b0, quotient};

   mtgrm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      state_in  = state_ff;
      sel_in    = sel_ff;
      wr_en     = 1'b0;
      wr_ch     = sel_ff;
      wr_data   = ent_cur;
      div_start = 1'b0;
      acc_in[0] = acc_ff[0];
      acc_in[1] = acc_ff[1];
      case (state_ff)
         S_IDLE: begin
            if (req_acc) state_in = S_RD1;
         end
         S_RD1: state_in = S_RD2;
         S_RD2: state_in = S_DEC;
         S_DEC: begin
            sel_in = 1'b0;
            if (!trk_ok_ff) begin
               state_in = (func_ff == FUNC_MIX && last_ff) ? S_EMIT : S_IDLE;
            end else begin
               case (func_ff)
                  FUNC_MIX: state_in = S_MUL;
                  FUNC_END: state_in = S_FIN;
                  FUNC_SET: begin
                     state_in = S_IDLE;
                     if (ent_sel.tgt != gv_ff) begin
                        wr_en   = 1'b1;
                        wr_ch   = ch_ff;
                        wr_data = '{now: to_q16(gv_ff), step: 32'd0, tgt: gv_ff};
                     end
                  end
                  FUNC_RAMP: begin
                     if (ent_sel.tgt == gv_ff) begin
                        state_in = S_IDLE;
                     end else begin
                        div_start = 1'b1;
                        state_in  = S_DIV;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_MUL: begin
            // advance the running gain of a ramping track once per frame
            if (ramping) begin
               wr_en   = 1'b1;
               wr_data = '{now: adv_sum, step: ent_cur.step, tgt: ent_cur.tgt};
            end
            state_in = S_ACC;
         end
         S_ACC: begin
            acc_in[sel_ff] = acc_ff[sel_ff] + prod_ff;
            if (!sel_ff) begin
               sel_in   = 1'b1;
               state_in = S_MUL;
            end else begin
               state_in = last_ff ? S_EMIT : S_IDLE;
            end
         end
         S_FIN: begin
            // snap a ramp that reaches its target in the next frame
            if (fin_hit) begin
               wr_en   = 1'b1;
               wr_data = '{now: to_q16(ent_cur.tgt), step: 32'd0, tgt: ent_cur.tgt};
            end
            if (!sel_ff) sel_in = 1'b1;
            else state_in = S_IDLE;
         end
         S_DIV: begin
            if (div_done) begin
               wr_en    = 1'b1;
               wr_ch    = ch_ff;
               wr_data  = '{now: (step_new == 32'd0) ? to_q16(gv_ff) : to_q16(ent_sel.tgt),
                            step: step_new, tgt: gv_ff};
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (rsp_load) begin
               acc_in[0] = 32'd0;
               acc_in[1] = 32'd0;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         sel_ff    <= 1'b0;
         acc_ff[0] <= 32'd0;
         acc_ff[1] <= 32'd0;
      end else begin
         state_ff  <= state_in;
         sel_ff    <= sel_in;
         acc_ff[0] <= acc_in[0];
         acc_ff[1] <= acc_in[1];
      end
      prod_ff <= 32'(gain_op) * 32'(samp_op);
      if (req_acc) begin
         func_ff   <= req_tuser[1:0];
         mono_ff   <= req_tuser[2];
         trk_ff    <= req_track;
         trk_ok_ff <= ({1'b0, req_track} < 6'(TRACKS));
         ch_ff     <= req_tdata[5];
         gv_ff     <= req_tdata[20:6];
         sl_ff     <= req_tdata[36:21];
         sr_ff     <= req_tdata[52:37];
         last_ff   <= req_tlast;
      end
      // capture both channels of the track
      if (state_ff == S_RD1) ent_ff[0] <= rd_ent;
      if (state_ff == S_RD2) ent_ff[1] <= rd_ent;
   end

   // result word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) rsp_data_ff <= {sat16(acc_ff[1]), sat16(acc_ff[0])};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_frames_ff <= RAMP_FRAMES_RST;
      end else if (csr_wr && csr_paddr[2] == REG_RAMP_FRAMES) begin
         ramp_frames_ff <= csr_pwdata[15:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_RAMP_FRAMES) ? {16'd0, ramp_frames_ff} : 32'd0;

   // the divider reports only for a ramp command in flight
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider done outside ramp setup");

   a_acc_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (acc_ff[0] == 32'd0 && acc_ff[1] == 32'd0))
      else $error("accumulators not cleared after frame");

   a_wr_valid_track: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> trk_ok_ff)
      else $error("gain table write for track out of range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> !(state_ff == S_IDLE && $past(state_ff) == S_EMIT))
      else $error("pending result word overwritten");

endmodule

// ----- rtl/core/mtgrm_div.sv -----
module mtgrm_div import mtgrm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;

   logic [DVS_W:0] rem_sh;
   logic [DVS_W:0] trial;

   assign rem_sh = {rem_ff, quo_ff[DVD_W-1]};
   assign trial  = rem_sh - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // restoring step: one quotient bit a cycle
         if (!trial[DVS_W]) begin
            rem_in = trial[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
